// File: hw/rtl/qpht_pkg.sv
package qpht_pkg;

  localparam int MaxSlots = 128;
  localparam int IdxW     = 7;
  localparam int CntW     = 8;
  localparam int KeyChars = 14;
  localparam int KeyW     = 112;
  localparam int HashW    = 18;
  localparam int RemW     = 22;
  localparam int ModSteps = 15;
  localparam int StepW    = 4;

  localparam logic [IdxW-1:0] InitSize = 7'd11;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActSearch = 2'd1;
  localparam logic [1:0] ActDelete = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatMissing = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;

  // Request to the remainder unit.
  typedef struct packed {
    logic             start;
    logic [HashW-1:0] num;
    logic [IdxW-1:0]  den;
  } mod_req_t;

  // Smallest prime of at least twice the size that fits, or zero.
  function automatic logic [IdxW-1:0] next_size(input logic [IdxW-1:0] size);
    logic [IdxW-1:0] r;
    unique case (size)
      7'd11:   r = 7'd23;
      7'd23:   r = 7'd47;
      7'd47:   r = 7'd97;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Zero every byte from the first zero byte onward.
  function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic            ended;
    r     = '0;
    ended = 1'b0;
    for (int b = 0; b < 14; b++) begin
      if (b >= KeyChars || k[KeyW-1-8*b -: 8] == 8'd0) ended = 1'b1;
      if (!ended) r[KeyW-1-8*b -: 8] = k[KeyW-1-8*b -: 8];
    end
    return r;
  endfunction

  // Weighted sum of the first three key bytes.
  function automatic logic [HashW-1:0] key_hash(input logic [KeyW-1:0] k);
    logic [HashW-1:0] c0, c1, c2;
    c0 = HashW'(k[KeyW-1 -: 8]);
    c1 = HashW'(k[KeyW-9 -: 8]);
    c2 = HashW'(k[KeyW-17 -: 8]);
    return HashW'(c0 + HashW'(27) * c1 + HashW'(729) * c2);
  endfunction

endpackage

// File: hw/rtl/qpht_ram.sv
module qpht_ram #(
  parameter int Depth = 128,
  parameter int Width = 112
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/qpht_mod.sv
module qpht_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qpht_pkg::mod_req_t        req_i,
  output logic                      done_o,
  output logic [qpht_pkg::IdxW-1:0] rem_o
);
  import qpht_pkg::*;

  logic [RemW-1:0]  rem_q;
  logic [IdxW-1:0]  den_q;
  logic [StepW-1:0] k_q;
  logic             busy_q;
  logic             done_q;
  logic [RemW-1:0]  shifted;

  assign shifted = RemW'(den_q) << k_q;

  // Restoring remainder, one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      den_q  <= '0;
      k_q    <= '0;
    end else if (req_i.start) begin
      rem_q  <= RemW'(req_i.num);
      den_q  <= req_i.den;
      k_q    <= StepW'(ModSteps - 1);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (rem_q >= shifted) rem_q <= rem_q - shifted;
      if (k_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        k_q <= k_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IdxW-1:0];

endmodule

// File: hw/rtl/quadratic_probe_hash_table.sv
// Steps per request: an insert waits for the remainder unit to give the home slot, then reads
// and checks each probe up to a free slot or a full table; search and delete read and compare
// each slot in turn up to the match or the end of the table; an unused action goes straight to
// the result. A rehash clears the scratch bank, reads each old slot, and for each used entry takes
// a new home from the remainder unit and probes the scratch bank. One request at a time; the next
// is taken in the cycle after the result loads. Reset holds requests off while both banks clear.
module quadratic_probe_hash_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic [63:0]               key_high_i,
  input  logic [47:0]               key_low_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [qpht_pkg::IdxW-1:0] slot_index_o,
  output logic [qpht_pkg::IdxW-1:0] current_size_o,
  output logic [qpht_pkg::CntW-1:0] stored_count_o,
  output logic                      grew_o,
  output logic                      growth_refused_o
);
  import qpht_pkg::*;

  localparam logic [3:0] StClr      = 4'd0;
  localparam logic [3:0] StIdle     = 4'd1;
  localparam logic [3:0] StHome     = 4'd2;
  localparam logic [3:0] StProbeRd  = 4'd3;
  localparam logic [3:0] StProbeChk = 4'd4;
  localparam logic [3:0] StRhClr    = 4'd5;
  localparam logic [3:0] StRhRd     = 4'd6;
  localparam logic [3:0] StRhChk    = 4'd7;
  localparam logic [3:0] StRhHome   = 4'd8;
  localparam logic [3:0] StRhPrbRd  = 4'd9;
  localparam logic [3:0] StRhPrbChk = 4'd10;
  localparam logic [3:0] StScRd     = 4'd11;
  localparam logic [3:0] StScCmp    = 4'd12;
  localparam logic [3:0] StDone     = 4'd13;

  logic [3:0]          state_q;
  logic [1:0]          act_q;
  logic [KeyW-1:0]     key_q, rk_q;
  logic [IdxW-1:0]     size_q, newsz_q, home_q, q_q, d_q, slot_q, trk_q;
  logic [CntW-1:0]     count_q, i_q, j_q;
  logic                bank_q;
  logic [1:0]          res_stat_q;
  logic                res_grew_q, res_ref_q;

  logic [1:0]          out_stat_q;
  logic [IdxW-1:0]     out_slot_q, out_size_q;
  logic [CntW-1:0]     out_cnt_q;
  logic                out_valid_q, out_grew_q, out_ref_q;

  logic [KeyW-1:0]     in_key, rd_key;
  logic [KeyW:0]       rdata, rdata0, rdata1, wdata;
  logic                rd_used, hit, rbank, out_load;
  logic [IdxW-1:0]     psize, idx, qn, dn, raddr, waddr, ns;
  logic [CntW-1:0]     psum, qsum, dsum, cnt_inc;
  logic                we, wbank, wboth;
  mod_req_t            mreq;
  logic                mdone;
  logic [IdxW-1:0]     mrem;

  assign in_key = norm_key({key_high_i, key_low_i});
  assign in_ready_o = (state_q == StIdle);

  // Probe position and the incremental square update, each one wrap.
  assign psize = (state_q == StRhPrbRd || state_q == StRhPrbChk) ? newsz_q : size_q;
  assign psum  = CntW'(home_q) + CntW'(q_q);
  assign idx   = (psum >= CntW'(psize)) ? IdxW'(psum - CntW'(psize)) : IdxW'(psum);
  assign qsum  = CntW'(q_q) + CntW'(d_q);
  assign qn    = (qsum >= CntW'(psize)) ? IdxW'(qsum - CntW'(psize)) : IdxW'(qsum);
  assign dsum  = CntW'(d_q) + CntW'(2);
  assign dn    = (dsum >= CntW'(psize)) ? IdxW'(dsum - CntW'(psize)) : IdxW'(dsum);
  assign cnt_inc = count_q + 1'b1;
  assign ns      = next_size(size_q);

  // Each word holds the used bit above the key. The scratch bank is read only
  // while probing during a rehash.
  assign raddr = (state_q == StRhRd) ? j_q[IdxW-1:0] :
                 (state_q == StScRd) ? i_q[IdxW-1:0] : idx;
  assign rbank = (state_q == StRhPrbChk) ? !bank_q : bank_q;
  assign rdata = rbank ? rdata1 : rdata0;
  assign rd_used = rdata[KeyW];
  assign rd_key  = rdata[KeyW-1:0];
  assign hit     = rd_used && (rd_key == key_q);

  // Write port control. Every write lands before any later read of that entry whose
  // data is checked, since no state checks read data issued in the cycle of a write.
  always_comb begin
    we    = 1'b0;
    wboth = 1'b0;
    wbank = bank_q;
    waddr = idx;
    wdata = '0;
    unique case (state_q)
      StClr: begin
        we    = 1'b1;
        wboth = 1'b1;
        waddr = i_q[IdxW-1:0];
      end
      StProbeChk: begin
        we    = !rd_used;
        wdata = {1'b1, key_q};
      end
      StRhClr: begin
        we    = (i_q != CntW'(newsz_q));
        wbank = !bank_q;
        waddr = i_q[IdxW-1:0];
      end
      StRhPrbChk: begin
        we    = !rd_used;
        wbank = !bank_q;
        wdata = {1'b1, rk_q};
      end
      StScCmp: begin
        we    = hit && (act_q == ActDelete);
        waddr = i_q[IdxW-1:0];
        wdata = {1'b0, key_q};
      end
      default: ;
    endcase
  end

  qpht_ram #(.Depth(MaxSlots), .Width(KeyW + 1)) u_bank0 (
    .clk_i, .we_i(we && (wboth || !wbank)), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata0)
  );
  qpht_ram #(.Depth(MaxSlots), .Width(KeyW + 1)) u_bank1 (
    .clk_i, .we_i(we && (wboth || wbank)), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata1)
  );

  // Remainder requests for the home slot.
  always_comb begin
    mreq.start = 1'b0;
    mreq.num   = key_hash(in_key);
    mreq.den   = size_q;
    if (state_q == StIdle && in_valid_i && action_i == ActInsert) begin
      mreq.start = 1'b1;
    end else if (state_q == StRhChk && rd_used) begin
      mreq.start = 1'b1;
      mreq.num   = key_hash(rd_key);
      mreq.den   = newsz_q;
    end
  end

  qpht_mod u_mod (.clk_i, .rst_ni, .req_i(mreq), .done_o(mdone), .rem_o(mrem));

  assign out_load = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Main sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      size_q  <= InitSize;
      count_q <= '0;
      bank_q  <= 1'b0;
      act_q <= '0; key_q <= '0; rk_q <= '0; newsz_q <= '0; home_q <= '0;
      q_q <= '0; d_q <= '0; slot_q <= '0; trk_q <= '0; i_q <= '0; j_q <= '0;
      res_stat_q <= '0; res_grew_q <= 1'b0; res_ref_q <= 1'b0;
    end else begin
      unique case (state_q)
        StClr: begin
          if (i_q == CntW'(MaxSlots - 1)) begin
            i_q     <= '0;
            state_q <= StIdle;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            act_q      <= action_i;
            key_q      <= in_key;
            i_q        <= '0;
            slot_q     <= '0;
            res_stat_q <= StatMissing;
            res_grew_q <= 1'b0;
            res_ref_q  <= 1'b0;
            if (action_i == ActInsert) state_q <= StHome;
            else if (action_i == ActSearch || action_i == ActDelete) state_q <= StScRd;
            else state_q <= StDone;
          end
        end
        StHome: begin
          if (mdone) begin
            home_q  <= mrem;
            q_q     <= '0;
            d_q     <= IdxW'(1);
            state_q <= StProbeRd;
          end
        end
        StProbeRd: begin
          if (i_q == CntW'(size_q)) begin
            res_stat_q <= StatFull;
            state_q    <= StDone;
          end else begin
            state_q <= StProbeChk;
          end
        end
        StProbeChk: begin
          if (!rd_used) begin
            count_q    <= cnt_inc;
            slot_q     <= idx;
            trk_q      <= idx;
            res_stat_q <= StatOk;
            if (cnt_inc >= CntW'(size_q >> 1)) begin
              if (ns == '0) begin
                res_ref_q <= 1'b1;
                state_q   <= StDone;
              end else begin
                res_grew_q <= 1'b1;
                newsz_q    <= ns;
                i_q        <= '0;
                j_q        <= '0;
                state_q    <= StRhClr;
              end
            end else begin
              state_q <= StDone;
            end
          end else begin
            i_q     <= i_q + 1'b1;
            q_q     <= qn;
            d_q     <= dn;
            state_q <= StProbeRd;
          end
        end
        StRhClr: begin
          if (i_q == CntW'(newsz_q)) state_q <= StRhRd;
          else i_q <= i_q + 1'b1;
        end
        StRhRd: begin
          if (j_q == CntW'(size_q)) begin
            bank_q  <= !bank_q;
            size_q  <= newsz_q;
            state_q <= StDone;
          end else begin
            state_q <= StRhChk;
          end
        end
        StRhChk: begin
          if (rd_used) begin
            rk_q    <= rd_key;
            state_q <= StRhHome;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= StRhRd;
          end
        end
        StRhHome: begin
          if (mdone) begin
            home_q  <= mrem;
            q_q     <= '0;
            d_q     <= IdxW'(1);
            i_q     <= '0;
            state_q <= StRhPrbRd;
          end
        end
        StRhPrbRd: begin
          if (i_q == CntW'(newsz_q)) begin
            j_q     <= j_q + 1'b1;
            state_q <= StRhRd;
          end else begin
            state_q <= StRhPrbChk;
          end
        end
        StRhPrbChk: begin
          if (!rd_used) begin
            if (j_q[IdxW-1:0] == trk_q) slot_q <= idx;
            j_q     <= j_q + 1'b1;
            state_q <= StRhRd;
          end else begin
            i_q     <= i_q + 1'b1;
            q_q     <= qn;
            d_q     <= dn;
            state_q <= StRhPrbRd;
          end
        end
        StScRd: begin
          if (i_q == CntW'(size_q)) state_q <= StDone;
          else state_q <= StScCmp;
        end
        StScCmp: begin
          if (hit) begin
            res_stat_q <= StatOk;
            slot_q     <= i_q[IdxW-1:0];
            if (act_q == ActDelete && count_q != '0) count_q <= count_q - 1'b1;
            state_q <= StDone;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= StScRd;
          end
        end
        StDone: begin
          if (out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Result register; a new result may load in the cycle the old one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_stat_q <= '0; out_slot_q <= '0; out_size_q <= '0; out_cnt_q <= '0;
      out_grew_q <= 1'b0; out_ref_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_stat_q  <= res_stat_q;
      out_slot_q  <= slot_q;
      out_size_q  <= size_q;
      out_cnt_q   <= count_q;
      out_grew_q  <= res_grew_q;
      out_ref_q   <= res_ref_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_stat_q;
  assign slot_index_o     = out_slot_q;
  assign current_size_o   = out_size_q;
  assign stored_count_o   = out_cnt_q;
  assign grew_o           = out_grew_q;
  assign growth_refused_o = out_ref_q;

endmodule

// File: hw/rtl/qpht_checker.sv
module qpht_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [1:0]                status_o,
  input logic [qpht_pkg::IdxW-1:0] slot_index_o,
  input logic [qpht_pkg::IdxW-1:0] current_size_o,
  input logic [qpht_pkg::CntW-1:0] stored_count_o,
  input logic                      grew_o,
  input logic                      growth_refused_o
);
  import qpht_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_index_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Only a successful insert may grow or refuse.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (grew_o || growth_refused_o) |-> status_o == StatOk && !(grew_o && growth_refused_o))
    else $error("growth flags on a failed request");

  // The size is always one of the prime steps.
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> current_size_o == 7'd11 || current_size_o == 7'd23
                 || current_size_o == 7'd47 || current_size_o == 7'd97)
    else $error("illegal table size");

  // Count never exceeds the size and slots lie inside the table.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stored_count_o <= CntW'(current_size_o) && slot_index_o < current_size_o)
    else $error("count or slot out of range");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qpht_pkg::*;

  typedef struct {
    logic [1:0]      status;
    logic [IdxW-1:0] slot;
    logic [IdxW-1:0] size;
    logic [CntW-1:0] count;
    logic            grew;
    logic            refused;
  } hash_result_t;

  typedef struct {
    logic [1:0]   act;
    logic [63:0]  kh;
    logic [47:0]  kl;
    bit           typed;
    hash_result_t res;
  } request_row_t;

  localparam int NumRows     = 14;
  localparam int NumRandom   = 1900;
  localparam int PoolSize    = 32;
  localparam int IdleLimit   = 20000;
  localparam int HoldCycles  = 3000;
  localparam int HoldAtCount = 300;

  localparam logic [1:0] ActUnused = 2'd3;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [1:0]      action_i = ActInsert;
  logic [63:0]     key_high_i = '0;
  logic [47:0]     key_low_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [1:0]      status_o;
  logic [IdxW-1:0] slot_index_o;
  logic [IdxW-1:0] current_size_o;
  logic [CntW-1:0] stored_count_o;
  logic            grew_o;
  logic            growth_refused_o;

  quadratic_probe_hash_table dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table.
  logic [KeyW-1:0] shadow_key[MaxSlots];
  bit              shadow_used[MaxSlots];
  int              shadow_size = int'(InitSize);
  int              shadow_count = 0;

  hash_result_t pending_results[$];
  request_row_t rows[NumRows];
  logic [KeyW-1:0] key_pool[PoolSize];
  bit  failed = 1'b0;
  bit  stimulus_done = 1'b0;
  int  results_seen = 0;

  // Zero every byte from the first zero byte onward.
  function automatic logic [KeyW-1:0] clean_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    bit ended;
    r = '0;
    ended = 1'b0;
    for (int b = 0; b < 14; b++) begin
      if (b >= KeyChars || k[KeyW-1-8*b -: 8] == 8'd0) ended = 1'b1;
      if (!ended) r[KeyW-1-8*b -: 8] = k[KeyW-1-8*b -: 8];
    end
    return r;
  endfunction

  function automatic int home_of(input logic [KeyW-1:0] k, input int size);
    int c0, c1, c2;
    c0 = int'(k[111:104]);
    c1 = int'(k[103:96]);
    c2 = int'(k[95:88]);
    return (c0 + 27 * c1 + 729 * c2) % size;
  endfunction

  // First free quadratic probe position, or -1.
  function automatic int first_free(input logic [KeyW-1:0] k, input int size,
                                    input bit used[MaxSlots]);
    int home, idx;
    home = home_of(k, size);
    for (int i = 0; i < size; i++) begin
      idx = (home + i * i) % size;
      if (idx < MaxSlots && !used[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic int grown_size(input int size);
    bit prime;
    for (int b = 2 * size; b <= MaxSlots; b++) begin
      prime = 1'b1;
      for (int d = 2; d * d <= b; d++) if (b % d == 0) prime = 1'b0;
      if (prime) return b;
    end
    return 0;
  endfunction

  // Moves every entry into a table of target_size; returns where slot tracked went.
  function automatic int regrow(input int target_size, input int tracked);
    logic [KeyW-1:0] nkey[MaxSlots];
    bit nused[MaxSlots];
    int p, where;
    where = 0;
    for (int i = 0; i < MaxSlots; i++) nused[i] = 1'b0;
    for (int i = 0; i < shadow_size; i++) begin
      if (!shadow_used[i]) continue;
      p = first_free(shadow_key[i], target_size, nused);
      if (p < 0) continue;
      nkey[p] = shadow_key[i];
      nused[p] = 1'b1;
      if (i == tracked) where = p;
    end
    for (int i = 0; i < target_size; i++) begin
      shadow_key[i] = nkey[i];
      shadow_used[i] = nused[i];
    end
    shadow_size = target_size;
    return where;
  endfunction

  // Applies one request to the shadow table and returns its result.
  function automatic hash_result_t apply_request(input logic [1:0] act,
                                                 input logic [63:0] kh,
                                                 input logic [47:0] kl);
    hash_result_t r;
    logic [KeyW-1:0] k;
    int p, ns;
    k = clean_key({kh, kl});
    r = '{StatMissing, '0, '0, '0, 1'b0, 1'b0};
    if (act == ActInsert) begin
      p = first_free(k, shadow_size, shadow_used);
      if (p < 0) begin
        r.status = StatFull;
      end else begin
        r.status = StatOk;
        shadow_key[p] = k;
        shadow_used[p] = 1'b1;
        shadow_count++;
        if (shadow_count >= shadow_size / 2) begin
          ns = grown_size(shadow_size);
          if (ns == 0) begin
            r.refused = 1'b1;
          end else begin
            p = regrow(ns, p);
            r.grew = 1'b1;
          end
        end
        r.slot = IdxW'(p);
      end
    end else if (act == ActSearch || act == ActDelete) begin
      for (int i = 0; i < shadow_size; i++) begin
        if (shadow_used[i] && shadow_key[i] == k) begin
          r.status = StatOk;
          r.slot = IdxW'(i);
          if (act == ActDelete) begin
            shadow_used[i] = 1'b0;
            if (shadow_count > 0) shadow_count--;
          end
          break;
        end
      end
    end
    r.size = IdxW'(shadow_size);
    r.count = CntW'(shadow_count);
    return r;
  endfunction

  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] k;
    logic [31:0] w;
    int len;
    w = $urandom;
    k = {$urandom, $urandom, $urandom, w[15:0]};
    // Most keys end early; the bytes past the end stay random.
    if ($urandom_range(0, 3) != 0) begin
      len = $urandom_range(0, 13);
      k[KeyW-1-8*len -: 8] = 8'd0;
    end
    return k;
  endfunction

  // Directed requests; typed results are those obvious from reset state.
  initial begin
    rows[0]  = '{ActSearch, 64'h4100_0000_0000_0000, '0, 1'b1,
                 '{StatMissing, 7'd0, 7'd11, 8'd0, 1'b0, 1'b0}};
    rows[1]  = '{ActUnused, '1, '1, 1'b1,
                 '{StatMissing, 7'd0, 7'd11, 8'd0, 1'b0, 1'b0}};
    rows[2]  = '{ActDelete, '1, '1, 1'b1, '{StatMissing, 7'd0, 7'd11, 8'd0, 1'b0, 1'b0}};
    rows[3]  = '{ActInsert, 64'h4100_0000_0000_0000, '0, 1'b1,
                 '{StatOk, 7'd10, 7'd11, 8'd1, 1'b0, 1'b0}};
    rows[4]  = '{ActInsert, '0, '0, 1'b1, '{StatOk, 7'd0, 7'd11, 8'd2, 1'b0, 1'b0}};
    rows[5]  = '{ActInsert, '1, '1, 1'b0, '{default: '0}};
    rows[6]  = '{ActInsert, '1, '0, 1'b0, '{default: '0}};
    rows[7]  = '{ActInsert, 64'h4200_FFFF_FFFF_FFFF, '1, 1'b0, '{default: '0}};
    rows[8]  = '{ActInsert, 64'h4142_4300_0000_0000, '0, 1'b0, '{default: '0}};
    rows[9]  = '{ActSearch, 64'h4200_0000_0000_0000, '0, 1'b0, '{default: '0}};
    rows[10] = '{ActSearch, '1, '1, 1'b0, '{default: '0}};
    rows[11] = '{ActDelete, 64'h4100_0000_0000_0000, '0, 1'b0, '{default: '0}};
    rows[12] = '{ActDelete, 64'h4100_0000_0000_0000, '0, 1'b0, '{default: '0}};
    rows[13] = '{ActSearch, '0, '0, 1'b0, '{default: '0}};
    for (int i = 0; i < PoolSize; i++) key_pool[i] = random_key();
  end

  // Sends one request and waits for its acceptance.
  task automatic send_request(input logic [1:0] act, input logic [63:0] kh,
                              input logic [47:0] kl, input bit typed,
                              input hash_result_t typed_res);
    hash_result_t r;
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 7) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i = act;
    key_high_i = kh;
    key_low_i = kl;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_request(act, kh, kl);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  // Request stream: directed rows, then mostly pool keys with random noise.
  initial begin
    logic [KeyW-1:0] k;
    logic [1:0] act;
    int pick;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NumRows; i++)
      send_request(rows[i].act, rows[i].kh, rows[i].kl, rows[i].typed, rows[i].res);
    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) act = ActInsert;
      else if (pick < 70) act = ActSearch;
      else if (pick < 95) act = ActDelete;
      else act = ActUnused;
      if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, PoolSize - 1)];
      else k = random_key();
      send_request(act, k[111:48], k[47:0], 1'b0, '{default: '0});
    end
    in_valid_i = 1'b0;
    stimulus_done = 1'b1;
  end

  task automatic check_result(input hash_result_t e);
    if (status_o !== e.status) begin
      $display("%0t status expected %0d actual %0d", $time, e.status, status_o);
      failed = 1'b1;
    end
    if (slot_index_o !== e.slot) begin
      $display("%0t slot_index expected %0d actual %0d", $time, e.slot, slot_index_o);
      failed = 1'b1;
    end
    if (current_size_o !== e.size) begin
      $display("%0t current_size expected %0d actual %0d", $time, e.size,
               current_size_o);
      failed = 1'b1;
    end
    if (stored_count_o !== e.count) begin
      $display("%0t stored_count expected %0d actual %0d", $time, e.count,
               stored_count_o);
      failed = 1'b1;
    end
    if (grew_o !== e.grew) begin
      $display("%0t grew expected %0b actual %0b", $time, e.grew, grew_o);
      failed = 1'b1;
    end
    if (growth_refused_o !== e.refused) begin
      $display("%0t growth_refused expected %0b actual %0b", $time, e.refused,
               growth_refused_o);
      failed = 1'b1;
    end
  endtask

  // Result side with random stalls and one long hold-off.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = (results_seen == HoldAtCount) ? HoldCycles : $urandom_range(0, 15);
      if ($urandom_range(0, 7) == 0) stall = 0;
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t result with no request pending: status %0d slot %0d",
                 $time, status_o, slot_index_o);
        failed = 1'b1;
      end else begin
        check_result(pending_results.pop_front());
      end
    end
  end

  // Idle watchdog.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done);
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (!failed && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
